>>> hdl/assert_macros.svh
// Assertion macros shared by the tracker RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while the reset is asserted.
`define PBEET_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked property that also holds through reset.
`define PBEET_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> hdl/pbeet_pkg.sv
// Shared widths, codes and reset values of the per-bin envelope tracker.
// Depends on nothing; used by the channel interfaces and the top level.
package pbeet_pkg;

  localparam int VALUE_W = 32;
  localparam int BIN_W   = 8;
  localparam int KEPT_W  = 4;
  localparam int CMD_W   = 2;
  localparam int SIG_W   = 2;

  localparam logic [KEPT_W-1:0]  KEPT_RESET = 4'd5;
  // 1000.0 in unsigned Q16.16.
  localparam logic [VALUE_W-1:0] LOW_RESET  = 32'h03E8_0000;
  localparam logic [VALUE_W-1:0] HIGH_RESET = 32'h0000_0000;

  typedef enum logic [CMD_W-1:0] {
    CMD_RECORD = 2'd0,
    CMD_TEST   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  localparam logic signed [SIG_W-1:0] SIG_BELOW  = -2'sd1;
  localparam logic signed [SIG_W-1:0] SIG_INSIDE = 2'sd0;
  localparam logic signed [SIG_W-1:0] SIG_ABOVE  = 2'sd1;

endpackage

>>> hdl/pbeet_if.sv
// Valid/ready channel interfaces of the per-bin envelope tracker.
// Depends on pbeet_pkg for field widths.
interface pbeet_in_if import pbeet_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [BIN_W-1:0]   bin_index;
  logic [VALUE_W-1:0] sample_value;

  modport source (output valid, output command, output bin_index, output sample_value,
                  input ready);
  modport sink   (input valid, input command, input bin_index, input sample_value,
                  output ready);
endinterface

interface pbeet_out_if import pbeet_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SIG_W-1:0]  significance;
  logic [VALUE_W-1:0]       low_bound;
  logic [VALUE_W-1:0]       high_bound;

  modport source (output valid, output significance, output low_bound, output high_bound,
                  input ready);
  modport sink   (input valid, input significance, input low_bound, input high_bound,
                  output ready);
endinterface

interface pbeet_cfg_if import pbeet_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KEPT_W-1:0] extremes_kept;

  modport source (output valid, output extremes_kept, input ready);
  modport sink   (input valid, input extremes_kept, output ready);
endinterface

>>> hdl/per_bin_extreme_envelope_tracker.sv
// Per-bin extreme envelope tracker: top level, row-wide list memories and update logic.
// An item's row is read on its transfer; the update, row write-back and result register
// follow once the output register can take a result, and only then is another item taken.
// Reset clears control state and runs a clearing pass over every row of both memories,
// one bin row a cycle, during which no item is taken; configuration writes are always taken.
// Depends on pbeet_pkg, the interfaces in pbeet_if.sv and assert_macros.svh.
`include "assert_macros.svh"

module per_bin_extreme_envelope_tracker import pbeet_pkg::*; #(
  parameter int BIN_COUNT = 256,
  parameter int MAX_KEPT  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pbeet_cfg_if.sink   cfg_i,
  pbeet_in_if.sink    sample_i,
  pbeet_out_if.source result_o
);

  // Each bin owns one memory row holding all MAX_KEPT entries of a list, so a whole
  // list is read at once and written back at once.
  localparam int ADDR_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int IDX_W  = ((ADDR_W > BIN_W) ? ADDR_W : BIN_W) + 1;
  localparam int ROW_W  = MAX_KEPT * VALUE_W;
  // The register is four bits wide, so K can never exceed fifteen.
  localparam int KCAP   = (MAX_KEPT < 15) ? MAX_KEPT : 15;

  localparam logic [ADDR_W-1:0] LAST_ROW  = ADDR_W'(BIN_COUNT - 1);
  localparam logic [IDX_W-1:0]  BIN_LIMIT = IDX_W'(BIN_COUNT);
  localparam logic [ROW_W-1:0]  LOW_ROW   = {MAX_KEPT{LOW_RESET}};
  localparam logic [ROW_W-1:0]  HIGH_ROW  = {MAX_KEPT{HIGH_RESET}};

  // One-hot sequencer: clearing pass, waiting for an item, updating a row.
  typedef enum logic [2:0] {
    ST_INIT = 3'b001,
    ST_IDLE = 3'b010,
    ST_CALC = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [KEPT_W-1:0] kept_q;

  // Item held while its row is read and updated.
  cmd_e              cmd_q;
  logic [ADDR_W-1:0] addr_q;
  logic [VALUE_W-1:0] val_q;
  logic              in_range_q;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  logic signed [SIG_W-1:0] out_sig_q;
  logic [VALUE_W-1:0]      out_low_q, out_high_q;

  logic accept, fire;
  logic [IDX_W-1:0]  bin_wide;
  logic [ADDR_W-1:0] rd_addr;

  // ---------------------------------------------------------------------------------------
  // Configuration: K is written at any time the channel transfers; the clamp to the range
  // 1..KCAP is applied when it is used, so the register keeps the raw written value.
  // ---------------------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q <= KEPT_RESET;
    end else if (cfg_i.valid) begin
      kept_q <= cfg_i.extremes_kept;
    end
  end

  logic [KEPT_W-1:0] k_raw, k_eff;
  always_comb begin
    k_raw = (kept_q == '0) ? KEPT_W'(1) : kept_q;
    k_eff = (k_raw > KEPT_W'(KCAP)) ? KEPT_W'(KCAP) : k_raw;
  end

  // ---------------------------------------------------------------------------------------
  // Input side. An item is taken only in the idle state; it may be taken while an earlier
  // result still sits in the output register, since the update of this item completes only
  // once that register is free or being emptied.
  // ---------------------------------------------------------------------------------------
  assign sample_i.ready = (state_q == ST_IDLE);
  assign accept         = sample_i.valid && sample_i.ready;
  assign bin_wide       = IDX_W'(sample_i.bin_index);
  assign rd_addr        = bin_wide[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_e'(sample_i.command);
      addr_q     <= rd_addr;
      val_q      <= sample_i.sample_value;
      in_range_q <= (bin_wide < BIN_LIMIT);
    end
  end

  // ---------------------------------------------------------------------------------------
  // List memories. The read is issued on the transfer and its data stays registered until
  // the next transfer, so a stalled update still sees the row it started with. The write
  // port serves both the clearing pass and the write-back of an updated row.
  // ---------------------------------------------------------------------------------------
  logic [ROW_W-1:0] lo_mem [BIN_COUNT];
  logic [ROW_W-1:0] hi_mem [BIN_COUNT];
  logic [ROW_W-1:0] lo_rd_q, hi_rd_q;
  logic [ROW_W-1:0] lo_wr, hi_wr, lo_new_row, hi_new_row;
  logic [ADDR_W-1:0] wr_addr;
  logic             wr_en, row_we;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lo_rd_q <= lo_mem[rd_addr];
      hi_rd_q <= hi_mem[rd_addr];
    end
    if (wr_en) begin
      lo_mem[wr_addr] <= lo_wr;
      hi_mem[wr_addr] <= hi_wr;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sorted insertion. Entry 0 of each list is the boundary (Kth extreme). A value that
  // beats the boundary goes to the highest position j below K where it still beats the
  // entry; the entries under j move down by one and the old boundary drops out. Every
  // entry is worked out on its own from the compare vector, so there is no ripple.
  // ---------------------------------------------------------------------------------------
  logic [VALUE_W-1:0] lo_e  [MAX_KEPT];
  logic [VALUE_W-1:0] hi_e  [MAX_KEPT];
  logic [VALUE_W-1:0] lo_n  [MAX_KEPT];
  logic [VALUE_W-1:0] hi_n  [MAX_KEPT];
  logic [MAX_KEPT-1:0] lo_bt, hi_bt, lo_up, hi_up;
  logic [ROW_W-1:0]   lo_sh, hi_sh;

  always_comb begin
    lo_sh = lo_rd_q >> VALUE_W;
    hi_sh = hi_rd_q >> VALUE_W;
    for (int i = 0; i < MAX_KEPT; i++) begin
      lo_e[i]  = lo_rd_q[i*VALUE_W +: VALUE_W];
      hi_e[i]  = hi_rd_q[i*VALUE_W +: VALUE_W];
      lo_bt[i] = (i < int'(k_eff)) && (val_q < lo_e[i]);
      hi_bt[i] = (i < int'(k_eff)) && (val_q > hi_e[i]);
    end
    for (int i = 0; i < MAX_KEPT; i++) begin
      // Set when a position above this one takes the value, so this entry shifts down.
      lo_up[i] = |(lo_bt >> (i + 1));
      hi_up[i] = |(hi_bt >> (i + 1));
    end
    for (int i = 0; i < MAX_KEPT; i++) begin
      if (!lo_bt[0]) begin
        lo_n[i] = lo_e[i];
      end else if (lo_up[i]) begin
        lo_n[i] = lo_sh[i*VALUE_W +: VALUE_W];
      end else if (lo_bt[i]) begin
        lo_n[i] = val_q;
      end else begin
        lo_n[i] = lo_e[i];
      end
      if (!hi_bt[0]) begin
        hi_n[i] = hi_e[i];
      end else if (hi_up[i]) begin
        hi_n[i] = hi_sh[i*VALUE_W +: VALUE_W];
      end else if (hi_bt[i]) begin
        hi_n[i] = val_q;
      end else begin
        hi_n[i] = hi_e[i];
      end
      lo_new_row[i*VALUE_W +: VALUE_W] = lo_n[i];
      hi_new_row[i*VALUE_W +: VALUE_W] = hi_n[i];
    end
  end

  // ---------------------------------------------------------------------------------------
  // Command decode: the rows to write back and the result fields.
  // ---------------------------------------------------------------------------------------
  logic signed [SIG_W-1:0] res_sig;
  logic [VALUE_W-1:0]      res_low, res_high;
  logic [ROW_W-1:0]        lo_upd, hi_upd;

  always_comb begin
    res_sig  = SIG_INSIDE;
    res_low  = lo_e[0];
    res_high = hi_e[0];
    lo_upd   = lo_new_row;
    hi_upd   = hi_new_row;
    row_we   = 1'b0;
    unique case (cmd_q)
      CMD_RECORD: begin
        row_we   = 1'b1;
        res_low  = lo_n[0];
        res_high = hi_n[0];
      end
      CMD_TEST: begin
        // A value above the high boundary wins over one below the low boundary.
        if (val_q < lo_e[0]) begin
          res_sig = SIG_BELOW;
        end
        if (val_q > hi_e[0]) begin
          res_sig = SIG_ABOVE;
        end
      end
      CMD_CLEAR: begin
        row_we   = 1'b1;
        lo_upd   = LOW_ROW;
        hi_upd   = HIGH_ROW;
        res_low  = LOW_RESET;
        res_high = HIGH_RESET;
      end
      default: begin
        // The unused command only reports the current bounds.
      end
    endcase
    // A bin beyond the configured count leaves every list alone and reports zeros.
    if (!in_range_q) begin
      row_we   = 1'b0;
      res_sig  = SIG_INSIDE;
      res_low  = '0;
      res_high = '0;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequencer. The update completes once the output register is free or being emptied in
  // the same cycle; the row write-back happens in that same cycle.
  // ---------------------------------------------------------------------------------------
  assign fire = (state_q == ST_CALC) && (!out_valid_q || result_o.ready);

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      ST_INIT: begin
        if (clr_cnt_q == LAST_ROW) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_comb begin
    if (state_q == ST_INIT) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q;
      lo_wr   = LOW_ROW;
      hi_wr   = HIGH_ROW;
    end else begin
      wr_en   = fire && row_we;
      wr_addr = addr_q;
      lo_wr   = lo_upd;
      hi_wr   = hi_upd;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Output register: one result per item, held until the sink takes the transfer.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_sig_q  <= res_sig;
      out_low_q  <= res_low;
      out_high_q <= res_high;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.significance = out_sig_q;
  assign result_o.low_bound    = out_low_q;
  assign result_o.high_bound   = out_high_q;

  // ---------------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------------
  `PBEET_ASSERT(a_accept_starts_update, clk_i, rst_ni, accept |=> (state_q == ST_CALC), "transfer did not start a row update")
  `PBEET_ASSERT(a_init_done_once, clk_i, rst_ni, (state_q == ST_IDLE) |=> (state_q != ST_INIT), "clearing pass restarted")
  `PBEET_ASSERT(a_clear_pass_complete, clk_i, rst_ni, (state_q != ST_INIT) |-> (clr_cnt_q == LAST_ROW), "items taken before every row was cleared")

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the per-bin extreme envelope tracker.
// Depends on pbeet_pkg and the channel interfaces in pbeet_if.sv, and on the tracker RTL.
`timescale 1ns / 1ps

module tb_top;
  import pbeet_pkg::*;

  localparam int BIN_COUNT      = 256;
  localparam int MAX_KEPT       = 8;
  // The command field is two bits wide but only three codes are defined. The fourth must
  // leave the bin untouched and simply report its bounds.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // After reset the block runs a clearing pass over its memories, and the sender and the
  // receiver each insert random stalls. This limit is generous against both.
  localparam int WATCHDOG_LIMIT = 4000;
  // Extra wait when draining, after the last expected result has come back.
  localparam int SETTLE_CYCLES  = 4;

  // One expected result of the tracker.
  typedef struct {
    logic signed [SIG_W-1:0] significance;
    logic [VALUE_W-1:0]      low_bound;
    logic [VALUE_W-1:0]      high_bound;
  } envelope_t;

  logic clk;
  logic rst_n;

  pbeet_cfg_if cfg_bus ();
  pbeet_in_if  sample_bus ();
  pbeet_out_if result_bus ();

  per_bin_extreme_envelope_tracker #(
    .BIN_COUNT(BIN_COUNT),
    .MAX_KEPT (MAX_KEPT)
  ) DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_i   (cfg_bus),
    .sample_i(sample_bus),
    .result_o(result_bus)
  );

  // Predictor state. Each row holds the extremes of one bin. Entry 0 of a row is the boundary
  // entry, that is the Kth lowest or the Kth highest value.
  logic [VALUE_W-1:0] low_rows  [BIN_COUNT][MAX_KEPT];
  logic [VALUE_W-1:0] high_rows [BIN_COUNT][MAX_KEPT];
  logic [KEPT_W-1:0]  kept_setting = KEPT_RESET;

  envelope_t pending_envelopes[$];
  int        mismatch_count = 0;
  int        idle_cycles    = 0;
  int        sink_stall     = 0;
  bit        sender_gapless = 1'b0;
  bit        sink_no_stall  = 1'b0;

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  function automatic void clear_row(int b);
    for (int i = 0; i < MAX_KEPT; i++) begin
      low_rows[b][i]  = LOW_RESET;
      high_rows[b][i] = HIGH_RESET;
    end
  endfunction

  // K as the hardware uses it: zero counts as one and anything above the list depth is
  // clipped to the depth.
  function automatic int kept_in_use();
    int k;
    k = kept_setting;
    if (k < 1) k = 1;
    if (k > MAX_KEPT) k = MAX_KEPT;
    return k;
  endfunction

  // Offer a recorded value to one list of a bin. The value gets in only if it beats the
  // boundary entry. It then takes the highest slot below K that it beats. The entries
  // beneath that slot move one place towards the boundary, and the old boundary drops out.
  // Slots at K and above are left alone, so their old contents survive a change of K.
  function automatic void offer_value(bit want_low, int b, int k, logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] row [MAX_KEPT];
    int                 slot;
    slot = -1;
    for (int i = 0; i < MAX_KEPT; i++) row[i] = want_low ? low_rows[b][i] : high_rows[b][i];
    if (want_low ? (v < row[0]) : (v > row[0])) begin
      for (int j = k - 1; j >= 0 && slot < 0; j--) begin
        if (want_low ? (v < row[j]) : (v > row[j])) slot = j;
      end
      for (int i = 1; i <= slot; i++) row[i-1] = row[i];
      row[slot] = v;
    end
    for (int i = 0; i < MAX_KEPT; i++) begin
      if (want_low) low_rows[b][i] = row[i];
      else high_rows[b][i] = row[i];
    end
  endfunction

  // Apply one accepted command to the predictor state and return the result it should cause.
  function automatic envelope_t predict_envelope(logic [CMD_W-1:0] cmd, logic [BIN_W-1:0] bin,
                                                 logic [VALUE_W-1:0] v);
    envelope_t e;
    int        b;
    int        k;
    b = bin;
    k = kept_in_use();
    e.significance = SIG_INSIDE;
    if (b >= BIN_COUNT) begin
      e.low_bound  = '0;
      e.high_bound = '0;
      return e;
    end
    case (cmd)
      CMD_RECORD: begin
        offer_value(1'b0, b, k, v);
        offer_value(1'b1, b, k, v);
      end
      CMD_TEST: begin
        // The test against the high envelope wins if both apply.
        if (v < low_rows[b][0]) e.significance = SIG_BELOW;
        if (v > high_rows[b][0]) e.significance = SIG_ABOVE;
      end
      CMD_CLEAR: clear_row(b);
      default: ;
    endcase
    e.low_bound  = low_rows[b][0];
    e.high_bound = high_rows[b][0];
    return e;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------

  // Send one command. The task is entered in the time step of a rising edge. It leaves
  // valid high after the transfer, so that a following item can go out back to back. With a
  // gap, valid is lowered first. In either case valid gets only one assignment per step.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [BIN_W-1:0] bin,
                           logic [VALUE_W-1:0] v);
    int gap;
    gap = sender_gapless ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_bus.valid        <= 1'b1;
    sample_bus.command      <= cmd;
    sample_bus.bin_index    <= bin;
    sample_bus.sample_value <= v;
    do @(posedge clk); while (!sample_bus.ready);
    pending_envelopes.push_back(predict_envelope(cmd, bin, v));
  endtask

  // Stop sending and wait until every expected result has come back. Then let the pipeline
  // settle.
  task automatic drain_results();
    sample_bus.valid <= 1'b0;
    wait (pending_envelopes.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write K. This happens only with the block idle, so the predictor takes the new value at
  // the transfer.
  task automatic write_kept(logic [KEPT_W-1:0] k);
    drain_results();
    cfg_bus.valid         <= 1'b1;
    cfg_bus.extremes_kept <= k;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    kept_setting = k;
  endtask

  // Reset value of K. Test and record on fresh bins. Values at both ends of the field. A test
  // exactly on a boundary. Clearing a bin. The unused command code.
  task automatic test_directed_commands();
    send_item(CMD_TEST,   8'd0,   32'h0000_0000);
    send_item(CMD_TEST,   8'd0,   32'hFFFF_FFFF);
    send_item(CMD_TEST,   8'd0,   LOW_RESET);
    send_item(CMD_RECORD, 8'd255, 32'h0000_0000);
    send_item(CMD_RECORD, 8'd255, 32'hFFFF_FFFF);
    send_item(CMD_TEST,   8'd255, 32'h0000_0000);
    for (int i = 1; i <= 5; i++) send_item(CMD_RECORD, 8'd3, (32'd100 * i) << 16);
    send_item(CMD_TEST,   8'd3,   32'd500 << 16);
    send_item(CMD_CLEAR,  8'd3,   32'hFFFF_FFFF);
    send_item(CMD_UNUSED, 8'd255, 32'h5555_AAAA);
    drain_results();
  endtask

  // K at its extremes: zero, the largest code, and changes of K while the lists hold data.
  task automatic test_kept_extremes();
    write_kept(4'd0);
    send_item(CMD_RECORD, 8'd20, 32'd300 << 16);
    send_item(CMD_RECORD, 8'd20, 32'd200 << 16);
    send_item(CMD_TEST,   8'd20, 32'd250 << 16);
    write_kept(4'd15);
    for (int i = 0; i < 8; i++) send_item(CMD_RECORD, 8'd21, (32'd37 * (i + 1)) << 16);
    write_kept(4'd2);
    send_item(CMD_RECORD, 8'd21, 32'h0000_0001);
    // Growing K again brings the stale entries back into the lists.
    write_kept(4'd8);
    send_item(CMD_TEST,   8'd21, 32'hFFFF_FFFF);
    drain_results();
  endtask

  // Random traffic in phases, each with its own K. Most items go to a few hot bins, so that
  // the lists fill and their boundaries move. The values are weighted towards the range
  // around the reset boundary of 1000.0, because a value has to lie below it to reach the
  // low list.
  task automatic test_random_traffic();
    int                 kept_plan [6];
    int                 sel;
    logic [CMD_W-1:0]   cmd;
    logic [BIN_W-1:0]   bin;
    logic [VALUE_W-1:0] v;
    kept_plan = '{5, 1, 8, 0, 15, 3};
    for (int phase = 0; phase < 6; phase++) begin
      write_kept((phase == 5) ? KEPT_W'($urandom_range(9, 14)) : KEPT_W'(kept_plan[phase]));
      for (int n = 0; n < 192; n++) begin
        // Change the pacing now and then. Some stretches run without any idling.
        if (n % 48 == 0) begin
          sender_gapless = ($urandom_range(0, 3) == 0);
          sink_no_stall  = ($urandom_range(0, 3) == 0);
        end
        // Halfway through each phase, hold off until the block has delivered everything.
        if (n == 96) drain_results();
        sel = $urandom_range(0, 99);
        if (sel < 60) cmd = CMD_RECORD;
        else if (sel < 90) cmd = CMD_TEST;
        else if (sel < 95) cmd = CMD_CLEAR;
        else cmd = CMD_UNUSED;
        sel = $urandom_range(0, 99);
        if (sel < 70) bin = BIN_W'($urandom_range(0, 3));
        else if (sel < 90) bin = BIN_W'($urandom_range(0, 15));
        else bin = BIN_W'($urandom_range(0, 255));
        sel = $urandom_range(0, 99);
        if (sel < 40) v = $urandom_range(0, 32'h07D0_0000);
        else if (sel < 70) v = $urandom;
        else if (sel < 85) v = LOW_RESET - 32'h0001_0000 + $urandom_range(0, 32'h0002_0000);
        else if (sel < 93) v = $urandom_range(0, 255);
        else v = 32'hFFFF_FFFF - $urandom_range(0, 255);
        send_item(cmd, bin, v);
      end
    end
    sender_gapless = 1'b0;
    sink_no_stall  = 1'b0;
    drain_results();
  endtask

  initial begin
    for (int b = 0; b < BIN_COUNT; b++) clear_row(b);
    rst_n                   <= 1'b0;
    cfg_bus.valid           <= 1'b0;
    cfg_bus.extremes_kept   <= KEPT_RESET;
    sample_bus.valid        <= 1'b0;
    sample_bus.command      <= CMD_RECORD;
    sample_bus.bin_index    <= '0;
    sample_bus.sample_value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_commands();
    test_kept_extremes();
    test_random_traffic();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_envelopes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------------------

  task automatic check_field(string name, longint expected, longint actual);
    if (expected !== actual) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, expected, actual);
      mismatch_count++;
    end
  endtask

  initial result_bus.ready = 1'b0;

  // Sample the result channel at each rising edge and compare each transfer with the oldest
  // expectation. After each transfer, draw a new stall for the receiver.
  always @(posedge clk) begin
    envelope_t expected;
    logic      next_ready;
    next_ready = result_bus.ready;
    if (result_bus.valid && result_bus.ready) begin
      if (pending_envelopes.size() == 0) begin
        $display("%0t ns: result with nothing expected, expected none, got %0d %h %h", $time,
                 result_bus.significance, result_bus.low_bound, result_bus.high_bound);
        mismatch_count++;
      end else begin
        expected = pending_envelopes.pop_front();
        check_field("significance", $signed(expected.significance),
                    $signed(result_bus.significance));
        check_field("low_bound", expected.low_bound, result_bus.low_bound);
        check_field("high_bound", expected.high_bound, result_bus.high_bound);
      end
      sink_stall = sink_no_stall ? 0 : $urandom_range(0, 6);
    end
    if (sink_stall > 0) begin
      sink_stall--;
      next_ready = 1'b0;
    end else begin
      next_ready = 1'b1;
    end
    result_bus.ready <= next_ready;
  end

  // The watchdog ends the run if no channel has had a transfer for too long.
  always @(posedge clk) begin
    if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
